### sv/jts_pkg.sv
// Shared types and codes for the JSON token scanner.
package jts_pkg;

	typedef enum logic [4:0] {
		M_VALUE  = 5'd0,
		M_KEY    = 5'd1,
		M_SEP    = 5'd2,
		M_STR    = 5'd3,
		M_ESC    = 5'd4,
		M_HEX    = 5'd5,
		M_BSL2   = 5'd6,
		M_U2     = 5'd7,
		M_COLON  = 5'd8,
		M_LIT    = 5'd9,
		M_NSIGN  = 5'd10,
		M_NZERO  = 5'd11,
		M_NINT   = 5'd12,
		M_NDOT   = 5'd13,
		M_NFRAC  = 5'd14,
		M_NE     = 5'd15,
		M_NESIGN = 5'd16,
		M_NEXP   = 5'd17
	} mode_t;

	localparam logic [3:0] K_BYTE      = 4'd0;
	localparam logic [3:0] K_KEY       = 4'd1;
	localparam logic [3:0] K_STRING    = 4'd2;
	localparam logic [3:0] K_NUMBER    = 4'd3;
	localparam logic [3:0] K_TRUE      = 4'd4;
	localparam logic [3:0] K_FALSE     = 4'd5;
	localparam logic [3:0] K_NULL      = 4'd6;
	localparam logic [3:0] K_ARR_START = 4'd7;
	localparam logic [3:0] K_ARR_END   = 4'd8;
	localparam logic [3:0] K_OBJ_START = 4'd9;
	localparam logic [3:0] K_OBJ_END   = 4'd10;
	localparam logic [3:0] K_SEP       = 4'd11;
	localparam logic [3:0] K_END       = 4'd12;
	localparam logic [3:0] K_ERROR     = 4'd13;

	localparam logic [3:0] E_STR   = 4'd0;
	localparam logic [3:0] E_ESC   = 4'd1;
	localparam logic [3:0] E_HEX   = 4'd2;
	localparam logic [3:0] E_UNI   = 4'd3;
	localparam logic [3:0] E_NUM   = 4'd4;
	localparam logic [3:0] E_LIT   = 4'd5;
	localparam logic [3:0] E_COLON = 4'd6;
	localparam logic [3:0] E_SEP   = 4'd7;
	localparam logic [3:0] E_DLM   = 4'd8;
	localparam logic [3:0] E_EARLY = 4'd9;
	localparam logic [3:0] E_BADC  = 4'd10;
	localparam logic [3:0] E_OVER  = 4'd11;

	localparam logic [1:0] LIT_TRUE  = 2'd0;
	localparam logic [1:0] LIT_FALSE = 2'd1;
	localparam logic [1:0] LIT_NULL  = 2'd2;

	// One result of a step.
	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] data;
		logic [3:0] err;
	} result_t;

	// Expected byte of a literal at a given position.
	function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] idx);
		logic [7:0] c;
		c = 8'h00;
		unique case (w)
			LIT_TRUE: begin
				unique case (idx)
					3'd1: c = "r";
					3'd2: c = "u";
					3'd3: c = "e";
					default: c = 8'h00;
				endcase
			end
			LIT_FALSE: begin
				unique case (idx)
					3'd1: c = "a";
					3'd2: c = "l";
					3'd3: c = "s";
					3'd4: c = "e";
					default: c = 8'h00;
				endcase
			end
			default: begin
				unique case (idx)
					3'd1: c = "u";
					3'd2: c = "l";
					3'd3: c = "l";
					default: c = 8'h00;
				endcase
			end
		endcase
		return c;
	endfunction

	function automatic logic [2:0] lit_len(input logic [1:0] w);
		return (w == LIT_FALSE) ? 3'd5 : 3'd4;
	endfunction

endpackage

### sv/json_token_scanner_core.sv
// Streaming JSON tokenizer: one text byte or end mark per transaction.
// Results of an input are registered and appear in the cycle after it is taken,
// then drain one result per cycle while m_tready is high, up to four per input.
// Throughput: one input per cycle while each input gives at most one result and
// m_tready is high; an input with more holds the input side until its last one drains.
// Reset: arst_n clears the mode, depth, escape and error state asynchronously.
module json_token_scanner_core #(
	parameter int STACK_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tuser,   // [0] end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [3:0] token_kind, [11:4] data_byte, [15:12] error_code
	output logic        m_tlast    // last_result
);

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [DW-1:0] DMAX = DW'(STACK_DEPTH);

	// Scanner state.
	jts_pkg::mode_t mode_q;
	logic [3:0]    err_code_q;
	logic          err_q;
	logic [DW-1:0] depth_q;
	logic [1:0]    lit_w_q;
	logic [2:0]    lit_i_q;
	logic [15:0]   hex_q;
	logic [2:0]    hex_n_q;
	logic [15:0]   hi_q;
	logic          in_key_q;
	logic          just_q;
	// The container type of the innermost level is kept in a register so the
	// stack memory is only written on open; the entry below it is read ahead every cycle.
	logic          top_q;
	logic          stack_mem [STACK_DEPTH];

	// Result buffer: up to four results being delivered.
	jts_pkg::result_t buf_q [4];
	logic [2:0] cnt_q;
	logic [1:0] rd_q;

	// Next-state logic.
	jts_pkg::mode_t mode_d;
	logic [3:0]    err_code_d;
	logic          err_d;
	logic [DW-1:0] depth_d;
	logic [1:0]    lit_w_d;
	logic [2:0]    lit_i_d;
	logic [15:0]   hex_d;
	logic [2:0]    hex_n_d;
	logic [15:0]   hi_d;
	logic          in_key_d, just_d;
	logic          push, pop, push_val;
	jts_pkg::result_t res [4];
	logic [2:0]    nres;

	logic [7:0] b;
	logic       eof;
	logic       take;
	logic [15:0] hacc;
	logic [20:0] cp;
	logic [3:0]  hv;
	logic        hv_ok;
	logic        ws, dig, close_ch, want;

	assign b    = s_tdata;
	assign eof  = s_tuser;
	assign take = s_tvalid && s_tready;
	// Accept whenever the buffer drains in this cycle or is empty.
	assign s_tready = (cnt_q == 3'd0) || (cnt_q == 3'd1 && m_tready);

	assign m_tvalid = (cnt_q != 3'd0);
	assign m_tdata  = {buf_q[rd_q].err, buf_q[rd_q].data, buf_q[rd_q].kind};
	assign m_tlast  = (cnt_q == 3'd1);

	always_comb begin
		hv_ok = 1'b1;
		hv = 4'd0;
		if (b >= "0" && b <= "9") hv = 4'(b - 8'h30);
		else if (b >= "a" && b <= "f") hv = 4'(b - 8'h57);
		else if (b >= "A" && b <= "F") hv = 4'(b - 8'h37);
		else hv_ok = 1'b0;
	end

	assign ws       = (b == 8'h20) || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0d);
	assign dig      = (b >= "0") && (b <= "9");
	assign close_ch = (b == "]") || (b == "}");
	assign want     = (b == "}");
	assign hacc     = {hex_q[11:0], hv};
	assign cp       = 21'h10000 + {1'b0, hi_q[9:0], hacc[9:0]};

	always_comb begin
		mode_d = mode_q;
		err_code_d = err_code_q;
		err_d = err_q;
		depth_d = depth_q;
		lit_w_d = lit_w_q;
		lit_i_d = lit_i_q;
		hex_d = hex_q;
		hex_n_d = hex_n_q;
		hi_d = hi_q;
		in_key_d = in_key_q;
		just_d = just_q;
		push = 1'b0;
		pop = 1'b0;
		push_val = 1'b0;
		nres = 3'd0;
		for (int i = 0; i < 4; i++) res[i] = '0;

		if (err_q) begin
			res[0] = '{jts_pkg::K_ERROR, 8'h00, err_code_q};
			nres = 3'd1;
		end else begin
			// A finished number falls through to separator handling.
			logic sep_go, do_close, do_fail;
			logic [3:0] fcode;
			sep_go = 1'b0;
			do_close = 1'b0;
			do_fail = 1'b0;
			fcode = jts_pkg::E_BADC;
			unique case (mode_q)
				jts_pkg::M_VALUE: begin
					if (eof) begin
						do_fail = 1'b1; fcode = jts_pkg::E_EARLY;
					end else if (ws) begin
					end else if (just_q && close_ch) begin
						do_close = 1'b1;
					end else begin
						just_d = 1'b0;
						if (b == "\"") begin
							in_key_d = 1'b0; mode_d = jts_pkg::M_STR;
						end else if (b == "[" || b == "{") begin
							if (depth_q >= DMAX) begin
								do_fail = 1'b1; fcode = jts_pkg::E_OVER;
							end else begin
								push = 1'b1; push_val = (b == "{");
								depth_d = depth_q + 1'b1;
								just_d = 1'b1;
								mode_d = push_val ? jts_pkg::M_KEY : jts_pkg::M_VALUE;
								res[0].kind = push_val ? jts_pkg::K_OBJ_START
								                       : jts_pkg::K_ARR_START;
								nres = 3'd1;
							end
						end else if (b == "-" || dig) begin
							res[0] = '{jts_pkg::K_BYTE, b, 4'd0};
							nres = 3'd1;
							mode_d = (b == "-") ? jts_pkg::M_NSIGN :
							         (b == "0") ? jts_pkg::M_NZERO : jts_pkg::M_NINT;
						end else if (b == "t" || b == "f" || b == "n") begin
							lit_w_d = (b == "t") ? jts_pkg::LIT_TRUE :
							          (b == "f") ? jts_pkg::LIT_FALSE : jts_pkg::LIT_NULL;
							lit_i_d = 3'd1;
							mode_d = jts_pkg::M_LIT;
						end else begin
							do_fail = 1'b1;
						end
					end
				end
				jts_pkg::M_KEY: begin
					if (eof) begin
						do_fail = 1'b1; fcode = jts_pkg::E_EARLY;
					end else if (ws) begin
					end else if (just_q && close_ch) begin
						do_close = 1'b1;
					end else if (b == "\"") begin
						in_key_d = 1'b1; just_d = 1'b0; mode_d = jts_pkg::M_STR;
					end else begin
						do_fail = 1'b1; fcode = jts_pkg::E_STR;
					end
				end
				jts_pkg::M_SEP: sep_go = 1'b1;
				jts_pkg::M_STR: begin
					if (eof) begin
						do_fail = 1'b1; fcode = jts_pkg::E_EARLY;
					end else if (b == "\"") begin
						if (in_key_q) mode_d = jts_pkg::M_COLON;
						else begin
							res[0].kind = jts_pkg::K_STRING; nres = 3'd1;
							mode_d = jts_pkg::M_SEP;
						end
					end else if (b == "\\") begin
						mode_d = jts_pkg::M_ESC;
					end else if (b < 8'h20) begin
						do_fail = 1'b1; fcode = jts_pkg::E_STR;
					end else begin
						res[0] = '{jts_pkg::K_BYTE, b, 4'd0}; nres = 3'd1;
					end
				end
				jts_pkg::M_ESC: begin
					if (eof) begin
						do_fail = 1'b1; fcode = jts_pkg::E_EARLY;
					end else begin
						mode_d = jts_pkg::M_STR;
						nres = 3'd1;
						res[0].kind = jts_pkg::K_BYTE;
						unique case (b)
							"\"", "\\", "/": res[0].data = b;
							"b": res[0].data = 8'h08;
							"f": res[0].data = 8'h0c;
							"n": res[0].data = 8'h0a;
							"r": res[0].data = 8'h0d;
							"t": res[0].data = 8'h09;
							"u": begin
								nres = 3'd0;
								hex_d = 16'h0; hex_n_d = 3'd0; mode_d = jts_pkg::M_HEX;
							end
							default: begin
								nres = 3'd0;
								do_fail = 1'b1; fcode = jts_pkg::E_ESC;
							end
						endcase
					end
				end
				jts_pkg::M_HEX: begin
					if (eof) begin
						do_fail = 1'b1; fcode = jts_pkg::E_EARLY;
					end else if (!hv_ok) begin
						do_fail = 1'b1; fcode = jts_pkg::E_HEX;
					end else begin
						hex_d = hacc;
						hex_n_d = hex_n_q + 3'd1;
						if (hex_n_q == 3'd3) begin
							if (hi_q != 16'h0) begin
								if (hacc >= 16'hdc00 && hacc <= 16'hdfff) begin
									res[0] = '{jts_pkg::K_BYTE, {5'b11110, cp[20:18]}, 4'd0};
									res[1] = '{jts_pkg::K_BYTE, {2'b10, cp[17:12]}, 4'd0};
									res[2] = '{jts_pkg::K_BYTE, {2'b10, cp[11:6]}, 4'd0};
									res[3] = '{jts_pkg::K_BYTE, {2'b10, cp[5:0]}, 4'd0};
									nres = 3'd4;
									hi_d = 16'h0;
									mode_d = jts_pkg::M_STR;
								end else begin
									do_fail = 1'b1; fcode = jts_pkg::E_UNI;
								end
							end else if (hacc >= 16'hd800 && hacc <= 16'hdbff) begin
								hi_d = hacc; mode_d = jts_pkg::M_BSL2;
							end else if (hacc >= 16'hdc00 && hacc <= 16'hdfff) begin
								do_fail = 1'b1; fcode = jts_pkg::E_UNI;
							end else begin
								mode_d = jts_pkg::M_STR;
								if (hacc < 16'h0080) begin
									res[0] = '{jts_pkg::K_BYTE, hacc[7:0], 4'd0};
									nres = 3'd1;
								end else if (hacc < 16'h0800) begin
									res[0] = '{jts_pkg::K_BYTE, {3'b110, hacc[10:6]}, 4'd0};
									res[1] = '{jts_pkg::K_BYTE, {2'b10, hacc[5:0]}, 4'd0};
									nres = 3'd2;
								end else begin
									res[0] = '{jts_pkg::K_BYTE, {4'b1110, hacc[15:12]}, 4'd0};
									res[1] = '{jts_pkg::K_BYTE, {2'b10, hacc[11:6]}, 4'd0};
									res[2] = '{jts_pkg::K_BYTE, {2'b10, hacc[5:0]}, 4'd0};
									nres = 3'd3;
								end
							end
						end
					end
				end
				jts_pkg::M_BSL2, jts_pkg::M_U2: begin
					if (eof) begin
						do_fail = 1'b1; fcode = jts_pkg::E_EARLY;
					end else if (mode_q == jts_pkg::M_BSL2 && b == "\\") begin
						mode_d = jts_pkg::M_U2;
					end else if (mode_q == jts_pkg::M_U2 && b == "u") begin
						hex_d = 16'h0; hex_n_d = 3'd0; mode_d = jts_pkg::M_HEX;
					end else begin
						do_fail = 1'b1; fcode = jts_pkg::E_UNI;
					end
				end
				jts_pkg::M_COLON: begin
					if (eof) begin
						do_fail = 1'b1; fcode = jts_pkg::E_EARLY;
					end else if (ws) begin
					end else if (b == ":") begin
						in_key_d = 1'b0;
						res[0].kind = jts_pkg::K_KEY; nres = 3'd1;
						mode_d = jts_pkg::M_VALUE;
					end else begin
						do_fail = 1'b1; fcode = jts_pkg::E_COLON;
					end
				end
				jts_pkg::M_LIT: begin
					if (eof) begin
						do_fail = 1'b1; fcode = jts_pkg::E_EARLY;
					end else if (lit_i_q < jts_pkg::lit_len(lit_w_q) &&
					             b == jts_pkg::lit_char(lit_w_q, lit_i_q)) begin
						lit_i_d = lit_i_q + 3'd1;
						if (lit_i_d >= jts_pkg::lit_len(lit_w_q)) begin
							res[0].kind = (lit_w_q == jts_pkg::LIT_TRUE)  ? jts_pkg::K_TRUE :
							              (lit_w_q == jts_pkg::LIT_FALSE) ? jts_pkg::K_FALSE :
							                                                jts_pkg::K_NULL;
							nres = 3'd1;
							mode_d = jts_pkg::M_SEP;
						end
					end else begin
						do_fail = 1'b1; fcode = jts_pkg::E_LIT;
					end
				end
				jts_pkg::M_NSIGN, jts_pkg::M_NDOT, jts_pkg::M_NE, jts_pkg::M_NESIGN: begin
					if (eof) begin
						do_fail = 1'b1; fcode = jts_pkg::E_EARLY;
					end else if (mode_q == jts_pkg::M_NE && (b == "+" || b == "-")) begin
						res[0] = '{jts_pkg::K_BYTE, b, 4'd0}; nres = 3'd1;
						mode_d = jts_pkg::M_NESIGN;
					end else if (dig) begin
						res[0] = '{jts_pkg::K_BYTE, b, 4'd0}; nres = 3'd1;
						unique case (mode_q)
							jts_pkg::M_NSIGN:
								mode_d = (b == "0") ? jts_pkg::M_NZERO : jts_pkg::M_NINT;
							jts_pkg::M_NDOT: mode_d = jts_pkg::M_NFRAC;
							default: mode_d = jts_pkg::M_NEXP;
						endcase
					end else begin
						do_fail = 1'b1; fcode = jts_pkg::E_NUM;
					end
				end
				jts_pkg::M_NZERO, jts_pkg::M_NINT, jts_pkg::M_NFRAC, jts_pkg::M_NEXP: begin
					if (!eof && dig && mode_q != jts_pkg::M_NZERO) begin
						res[0] = '{jts_pkg::K_BYTE, b, 4'd0}; nres = 3'd1;
					end else if (!eof && b == "." &&
					             (mode_q == jts_pkg::M_NZERO || mode_q == jts_pkg::M_NINT)) begin
						res[0] = '{jts_pkg::K_BYTE, b, 4'd0}; nres = 3'd1;
						mode_d = jts_pkg::M_NDOT;
					end else if (!eof && (b == "e" || b == "E") &&
					             mode_q != jts_pkg::M_NEXP) begin
						res[0] = '{jts_pkg::K_BYTE, b, 4'd0}; nres = 3'd1;
						mode_d = jts_pkg::M_NE;
					end else begin
						res[0].kind = jts_pkg::K_NUMBER; nres = 3'd1;
						mode_d = jts_pkg::M_SEP;
						sep_go = 1'b1;
					end
				end
				default: do_fail = 1'b1;
			endcase

			// Separator position, possibly after a number token in slot 0.
			if (sep_go) begin
				if (eof) begin
					if (depth_q == '0) begin
						res[nres[1:0]].kind = jts_pkg::K_END;
						nres = nres + 3'd1;
					end else begin
						do_fail = 1'b1; fcode = jts_pkg::E_EARLY;
					end
				end else if (ws) begin
				end else if (b == ",") begin
					if (depth_q == '0) begin
						do_fail = 1'b1; fcode = jts_pkg::E_SEP;
					end else begin
						mode_d = top_q ? jts_pkg::M_KEY : jts_pkg::M_VALUE;
						just_d = 1'b0;
						res[nres[1:0]].kind = jts_pkg::K_SEP;
						nres = nres + 3'd1;
					end
				end else if (close_ch) begin
					do_close = 1'b1;
				end else begin
					do_fail = 1'b1;
				end
			end

			if (do_close) begin
				if (depth_q == '0 || top_q != want) begin
					do_fail = 1'b1; fcode = jts_pkg::E_DLM;
				end else begin
					pop = 1'b1;
					depth_d = depth_q - 1'b1;
					just_d = 1'b0;
					mode_d = jts_pkg::M_SEP;
					res[nres[1:0]].kind = want ? jts_pkg::K_OBJ_END : jts_pkg::K_ARR_END;
					nres = nres + 3'd1;
				end
			end

			if (do_fail) begin
				err_d = 1'b1;
				err_code_d = fcode;
				res[nres[1:0]] = '{jts_pkg::K_ERROR, 8'h00, fcode};
				nres = nres + 3'd1;
			end
		end
	end

	// Stack: write on open. The entry below the top for the depth of the next
	// cycle is read into a register, so a close that follows at once already
	// has the container type of the level it returns to.
	logic [DW-1:0] depth_nx;
	logic [AW-1:0] rd_addr;
	logic          rd_data_q;
	assign depth_nx = take ? depth_d : depth_q;
	assign rd_addr  = AW'(depth_nx - DW'(2));

	always_ff @(posedge clk) begin
		if (take && push) stack_mem[AW'(depth_q)] <= push_val;
		rd_data_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jts_pkg::M_VALUE;
			err_code_q <= 4'd0;
			err_q <= 1'b0;
			depth_q <= '0;
			lit_w_q <= 2'd0;
			lit_i_q <= 3'd0;
			hex_q <= 16'h0;
			hex_n_q <= 3'd0;
			hi_q <= 16'h0;
			in_key_q <= 1'b0;
			just_q <= 1'b0;
			top_q <= 1'b0;
			cnt_q <= 3'd0;
			rd_q <= 2'd0;
		end else begin
			if (take) begin
				mode_q <= mode_d;
				err_code_q <= err_code_d;
				err_q <= err_d;
				depth_q <= depth_d;
				lit_w_q <= lit_w_d;
				lit_i_q <= lit_i_d;
				hex_q <= hex_d;
				hex_n_q <= hex_n_d;
				hi_q <= hi_d;
				in_key_q <= in_key_d;
				just_q <= just_d;
				if (push) top_q <= push_val;
				else if (pop) top_q <= (depth_q >= DW'(2)) ? rd_data_q : 1'b0;
				cnt_q <= nres;
				rd_q <= 2'd0;
			end else if (m_tvalid && m_tready) begin
				cnt_q <= cnt_q - 3'd1;
				rd_q <= rd_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < 4; i++) buf_q[i] <= res[i];
		end
	end

endmodule

### dv/tb.sv
// Self-checking testbench for the streaming JSON token scanner.
`timescale 1ns / 1ps

module tb;

	localparam int NEST_LIMIT = 256;
	localparam int DEEP_LEVELS = 32;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 370;

	typedef struct {
		logic [3:0] kind;
		logic [7:0] data;
		logic [3:0] err;
		logic       last;
	} token_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	json_token_scanner_core #(.STACK_DEPTH(NEST_LIMIT)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Expected tokens in arrival order, and the scanner state that produces them.
	token_t            token_q[$];
	int                mismatches = 0;
	int                sent_items = 0;
	int                cycles = 0;
	bit                calm = 1'b0;
	bit                first_elem = 1'b1;

	jts_pkg::mode_t    sc_mode;
	logic [3:0]        sc_err;
	bit [NEST_LIMIT-1:0] sc_stack;
	int                sc_depth;
	int                sc_word;
	int                sc_pos;
	logic [15:0]       sc_hex;
	int                sc_hex_n;
	logic [15:0]       sc_high;
	bit                sc_key;
	bit                sc_fresh;
	bit                sc_failed;
	int                step_tokens;

	function automatic bit is_space(logic [7:0] b);
		return b == " " || b == "\t" || b == "\n" || b == "\r";
	endfunction

	function automatic bit is_num(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic int nibble(logic [7:0] b);
		if (b >= "0" && b <= "9") return b - "0";
		if (b >= "a" && b <= "f") return b - "a" + 10;
		if (b >= "A" && b <= "F") return b - "A" + 10;
		return -1;
	endfunction

	task emit(logic [3:0] k, logic [7:0] d, logic [3:0] e);
		token_q.push_back('{k, d, e, 1'b0});
		step_tokens++;
	endtask

	task latch_error(logic [3:0] code);
		sc_failed = 1'b1;
		sc_err = code;
		emit(jts_pkg::K_ERROR, 8'h00, code);
	endtask

	task open_level(bit obj);
		if (sc_depth >= NEST_LIMIT) begin
			latch_error(jts_pkg::E_OVER);
		end else begin
			sc_stack[sc_depth] = obj;
			sc_depth++;
			sc_fresh = 1'b1;
			sc_mode = obj ? jts_pkg::M_KEY : jts_pkg::M_VALUE;
			emit(obj ? jts_pkg::K_OBJ_START : jts_pkg::K_ARR_START, 8'h00, 4'd0);
		end
	endtask

	task close_level(logic [7:0] b);
		bit obj;
		obj = (b == "}");
		if (sc_depth == 0 || sc_stack[sc_depth-1] != obj) begin
			latch_error(jts_pkg::E_DLM);
		end else begin
			sc_depth--;
			sc_fresh = 1'b0;
			sc_mode = jts_pkg::M_SEP;
			emit(obj ? jts_pkg::K_OBJ_END : jts_pkg::K_ARR_END, 8'h00, 4'd0);
		end
	endtask

	// Position after a complete value: separator, closer, or end of text.
	task after_value(logic [7:0] b, bit eof);
		if (eof) begin
			if (sc_depth == 0) emit(jts_pkg::K_END, 8'h00, 4'd0);
			else latch_error(jts_pkg::E_EARLY);
		end else if (is_space(b)) begin
		end else if (b == ",") begin
			if (sc_depth == 0) begin
				latch_error(jts_pkg::E_SEP);
			end else begin
				sc_mode = sc_stack[sc_depth-1] ? jts_pkg::M_KEY : jts_pkg::M_VALUE;
				sc_fresh = 1'b0;
				emit(jts_pkg::K_SEP, 8'h00, 4'd0);
			end
		end else if (b == "]" || b == "}") begin
			close_level(b);
		end else begin
			latch_error(jts_pkg::E_BADC);
		end
	endtask

	task start_value(logic [7:0] b, bit eof);
		if (eof) begin
			latch_error(jts_pkg::E_EARLY);
		end else if (is_space(b)) begin
		end else if (sc_fresh && (b == "]" || b == "}")) begin
			close_level(b);
		end else begin
			sc_fresh = 1'b0;
			if (b == "\"") begin
				sc_key = 1'b0;
				sc_mode = jts_pkg::M_STR;
			end else if (b == "[" || b == "{") begin
				open_level(b == "{");
			end else if (b == "-") begin
				emit(jts_pkg::K_BYTE, b, 4'd0);
				sc_mode = jts_pkg::M_NSIGN;
			end else if (b == "0") begin
				emit(jts_pkg::K_BYTE, b, 4'd0);
				sc_mode = jts_pkg::M_NZERO;
			end else if (is_num(b)) begin
				emit(jts_pkg::K_BYTE, b, 4'd0);
				sc_mode = jts_pkg::M_NINT;
			end else if (b == "t" || b == "f" || b == "n") begin
				sc_word = (b == "t") ? 0 : (b == "f") ? 1 : 2;
				sc_pos = 1;
				sc_mode = jts_pkg::M_LIT;
			end else begin
				latch_error(jts_pkg::E_BADC);
			end
		end
	endtask

	// Four hex digits are in: emit UTF-8, wait for the low half of a pair, or flag a lone half.
	task finish_escape;
		logic [31:0] cp;
		if (sc_high != 16'h0000) begin
			if (sc_hex >= 16'hdc00 && sc_hex <= 16'hdfff) begin
				cp = 32'h10000 + ({22'd0, sc_high[9:0]} << 10) + sc_hex[9:0];
				emit(jts_pkg::K_BYTE, 8'hf0 | cp[20:18], 4'd0);
				emit(jts_pkg::K_BYTE, 8'h80 | cp[17:12], 4'd0);
				emit(jts_pkg::K_BYTE, 8'h80 | cp[11:6], 4'd0);
				emit(jts_pkg::K_BYTE, 8'h80 | cp[5:0], 4'd0);
				sc_high = 16'h0000;
				sc_mode = jts_pkg::M_STR;
			end else begin
				latch_error(jts_pkg::E_UNI);
			end
		end else if (sc_hex >= 16'hd800 && sc_hex <= 16'hdbff) begin
			sc_high = sc_hex;
			sc_mode = jts_pkg::M_BSL2;
		end else if (sc_hex >= 16'hdc00 && sc_hex <= 16'hdfff) begin
			latch_error(jts_pkg::E_UNI);
		end else begin
			if (sc_hex < 16'h0080) begin
				emit(jts_pkg::K_BYTE, sc_hex[7:0], 4'd0);
			end else if (sc_hex < 16'h0800) begin
				emit(jts_pkg::K_BYTE, 8'hc0 | sc_hex[10:6], 4'd0);
				emit(jts_pkg::K_BYTE, 8'h80 | sc_hex[5:0], 4'd0);
			end else begin
				emit(jts_pkg::K_BYTE, 8'he0 | sc_hex[15:12], 4'd0);
				emit(jts_pkg::K_BYTE, 8'h80 | sc_hex[11:6], 4'd0);
				emit(jts_pkg::K_BYTE, 8'h80 | sc_hex[5:0], 4'd0);
			end
			sc_mode = jts_pkg::M_STR;
		end
	endtask

	task end_number(logic [7:0] b, bit eof);
		emit(jts_pkg::K_NUMBER, 8'h00, 4'd0);
		sc_mode = jts_pkg::M_SEP;
		after_value(b, eof);
	endtask

	// Works out the tokens of one accepted transaction and queues them.
	task predict_tokens(logic [7:0] b, bit eof);
		string word;
		int hv;
		step_tokens = 0;
		if (sc_failed) begin
			emit(jts_pkg::K_ERROR, 8'h00, sc_err);
		end else begin
			case (sc_mode)
				jts_pkg::M_VALUE: start_value(b, eof);
				jts_pkg::M_KEY: begin
					if (eof) latch_error(jts_pkg::E_EARLY);
					else if (is_space(b)) begin
					end else if (sc_fresh && (b == "]" || b == "}")) close_level(b);
					else if (b == "\"") begin
						sc_key = 1'b1;
						sc_fresh = 1'b0;
						sc_mode = jts_pkg::M_STR;
					end else latch_error(jts_pkg::E_STR);
				end
				jts_pkg::M_SEP: after_value(b, eof);
				jts_pkg::M_STR: begin
					if (eof) latch_error(jts_pkg::E_EARLY);
					else if (b == "\"") begin
						if (sc_key) sc_mode = jts_pkg::M_COLON;
						else begin
							emit(jts_pkg::K_STRING, 8'h00, 4'd0);
							sc_mode = jts_pkg::M_SEP;
						end
					end else if (b == "\\") sc_mode = jts_pkg::M_ESC;
					else if (b < 8'h20) latch_error(jts_pkg::E_STR);
					else emit(jts_pkg::K_BYTE, b, 4'd0);
				end
				jts_pkg::M_ESC: begin
					if (eof) latch_error(jts_pkg::E_EARLY);
					else begin
						sc_mode = jts_pkg::M_STR;
						case (b)
							"\"", "\\", "/": emit(jts_pkg::K_BYTE, b, 4'd0);
							"b": emit(jts_pkg::K_BYTE, 8'h08, 4'd0);
							"f": emit(jts_pkg::K_BYTE, 8'h0c, 4'd0);
							"n": emit(jts_pkg::K_BYTE, 8'h0a, 4'd0);
							"r": emit(jts_pkg::K_BYTE, 8'h0d, 4'd0);
							"t": emit(jts_pkg::K_BYTE, 8'h09, 4'd0);
							"u": begin
								sc_hex = 16'h0000;
								sc_hex_n = 0;
								sc_mode = jts_pkg::M_HEX;
							end
							default: latch_error(jts_pkg::E_ESC);
						endcase
					end
				end
				jts_pkg::M_HEX: begin
					hv = nibble(b);
					if (eof) latch_error(jts_pkg::E_EARLY);
					else if (hv < 0) latch_error(jts_pkg::E_HEX);
					else begin
						sc_hex = {sc_hex[11:0], hv[3:0]};
						sc_hex_n++;
						if (sc_hex_n >= 4) finish_escape();
					end
				end
				jts_pkg::M_BSL2: begin
					if (eof) latch_error(jts_pkg::E_EARLY);
					else if (b == "\\") sc_mode = jts_pkg::M_U2;
					else latch_error(jts_pkg::E_UNI);
				end
				jts_pkg::M_U2: begin
					if (eof) latch_error(jts_pkg::E_EARLY);
					else if (b == "u") begin
						sc_hex = 16'h0000;
						sc_hex_n = 0;
						sc_mode = jts_pkg::M_HEX;
					end else latch_error(jts_pkg::E_UNI);
				end
				jts_pkg::M_COLON: begin
					if (eof) latch_error(jts_pkg::E_EARLY);
					else if (is_space(b)) begin
					end else if (b == ":") begin
						sc_key = 1'b0;
						emit(jts_pkg::K_KEY, 8'h00, 4'd0);
						sc_mode = jts_pkg::M_VALUE;
					end else latch_error(jts_pkg::E_COLON);
				end
				jts_pkg::M_LIT: begin
					word = (sc_word == 0) ? "true" : (sc_word == 1) ? "false" : "null";
					if (eof) latch_error(jts_pkg::E_EARLY);
					else if (sc_pos < word.len() && b == word[sc_pos]) begin
						sc_pos++;
						if (sc_pos >= word.len()) begin
							emit((sc_word == 0) ? jts_pkg::K_TRUE :
								(sc_word == 1) ? jts_pkg::K_FALSE : jts_pkg::K_NULL,
								8'h00, 4'd0);
							sc_mode = jts_pkg::M_SEP;
						end
					end else latch_error(jts_pkg::E_LIT);
				end
				jts_pkg::M_NSIGN: begin
					if (eof) latch_error(jts_pkg::E_EARLY);
					else if (b == "0") begin
						emit(jts_pkg::K_BYTE, b, 4'd0);
						sc_mode = jts_pkg::M_NZERO;
					end else if (is_num(b)) begin
						emit(jts_pkg::K_BYTE, b, 4'd0);
						sc_mode = jts_pkg::M_NINT;
					end else latch_error(jts_pkg::E_NUM);
				end
				jts_pkg::M_NZERO, jts_pkg::M_NINT: begin
					if (!eof && sc_mode == jts_pkg::M_NINT && is_num(b))
						emit(jts_pkg::K_BYTE, b, 4'd0);
					else if (!eof && b == ".") begin
						emit(jts_pkg::K_BYTE, b, 4'd0);
						sc_mode = jts_pkg::M_NDOT;
					end else if (!eof && (b == "e" || b == "E")) begin
						emit(jts_pkg::K_BYTE, b, 4'd0);
						sc_mode = jts_pkg::M_NE;
					end else end_number(b, eof);
				end
				jts_pkg::M_NDOT: begin
					if (eof) latch_error(jts_pkg::E_EARLY);
					else if (is_num(b)) begin
						emit(jts_pkg::K_BYTE, b, 4'd0);
						sc_mode = jts_pkg::M_NFRAC;
					end else latch_error(jts_pkg::E_NUM);
				end
				jts_pkg::M_NFRAC: begin
					if (!eof && is_num(b)) emit(jts_pkg::K_BYTE, b, 4'd0);
					else if (!eof && (b == "e" || b == "E")) begin
						emit(jts_pkg::K_BYTE, b, 4'd0);
						sc_mode = jts_pkg::M_NE;
					end else end_number(b, eof);
				end
				jts_pkg::M_NE: begin
					if (eof) latch_error(jts_pkg::E_EARLY);
					else if (b == "+" || b == "-") begin
						emit(jts_pkg::K_BYTE, b, 4'd0);
						sc_mode = jts_pkg::M_NESIGN;
					end else if (is_num(b)) begin
						emit(jts_pkg::K_BYTE, b, 4'd0);
						sc_mode = jts_pkg::M_NEXP;
					end else latch_error(jts_pkg::E_NUM);
				end
				jts_pkg::M_NESIGN: begin
					if (eof) latch_error(jts_pkg::E_EARLY);
					else if (is_num(b)) begin
						emit(jts_pkg::K_BYTE, b, 4'd0);
						sc_mode = jts_pkg::M_NEXP;
					end else latch_error(jts_pkg::E_NUM);
				end
				jts_pkg::M_NEXP: begin
					if (!eof && is_num(b)) emit(jts_pkg::K_BYTE, b, 4'd0);
					else end_number(b, eof);
				end
				default: latch_error(jts_pkg::E_BADC);
			endcase
		end
		if (step_tokens > 0) token_q[token_q.size()-1].last = 1'b1;
	endtask

	// Sends one transaction, with an occasional idle burst in front of it.
	task send_item(logic [7:0] b, bit eof);
		if (!calm && $urandom_range(0, 11) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= eof;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_tokens(b, eof);
		sent_items++;
	endtask

	task send_text(string s);
		for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
	endtask

	// One element of the outer array, with its leading comma where needed.
	task send_element(string s);
		if (!first_elem) send_text(",");
		first_elem = 1'b0;
		send_text(s);
	endtask

	function automatic string blank();
		string s, pick;
		s = "";
		pick = " \t\n\r";
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 3)) s = {s, string'(pick[$urandom_range(0, 3)])};
		return s;
	endfunction

	function automatic string hex4(logic [15:0] v);
		string s, lo_d, up_d;
		lo_d = "0123456789abcdef";
		up_d = "0123456789ABCDEF";
		s = "";
		for (int i = 3; i >= 0; i--) begin
			if ($urandom_range(0, 1)) s = {s, string'(lo_d[(v >> (4*i)) & 15])};
			else s = {s, string'(up_d[(v >> (4*i)) & 15])};
		end
		return s;
	endfunction

	function automatic string rand_text_body();
		string s, esc;
		logic [7:0] c;
		s = "";
		esc = "\"\\/bfnrt";
		repeat ($urandom_range(0, 6)) begin
			case ($urandom_range(0, 7))
				0: s = {s, "\\", string'(esc[$urandom_range(0, 7)])};
				1: s = {s, "\\u", hex4($urandom_range(0, 16'h7f))};
				2: s = {s, "\\u", hex4($urandom_range(16'h80, 16'h7ff))};
				3: s = {s, "\\u", hex4($urandom_range(0, 1) ? $urandom_range(16'h800, 16'hd7ff)
					: $urandom_range(16'he000, 16'hffff))};
				4: s = {s, "\\u", hex4($urandom_range(16'hd800, 16'hdbff)),
					"\\u", hex4($urandom_range(16'hdc00, 16'hdfff))};
				5: s = {s, string'(8'($urandom_range(8'h80, 8'hff)))};
				default: begin
					c = $urandom_range(8'h20, 8'h7e);
					if (c == "\"" || c == "\\") c = "_";
					s = {s, string'(c)};
				end
			endcase
		end
		return s;
	endfunction

	function automatic string rand_digits(int lo);
		string s;
		s = "";
		repeat ($urandom_range(lo, 3)) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
		return s;
	endfunction

	function automatic string rand_number();
		string s;
		s = $urandom_range(0, 1) ? "-" : "";
		if ($urandom_range(0, 3) == 0) s = {s, "0"};
		else s = {s, string'(8'("1" + $urandom_range(0, 8))), rand_digits(0)};
		if ($urandom_range(0, 1)) s = {s, ".", rand_digits(1)};
		if ($urandom_range(0, 2) == 0) begin
			s = {s, $urandom_range(0, 1) ? "e" : "E"};
			case ($urandom_range(0, 2))
				0: s = {s, "+"};
				1: s = {s, "-"};
				default: ;
			endcase
			s = {s, rand_digits(1)};
		end
		return s;
	endfunction

	function automatic string rand_value(int lvl);
		string s;
		int n;
		case ($urandom_range(0, (lvl > 0) ? 5 : 3))
			0: s = rand_number();
			1, 3: s = {"\"", rand_text_body(), "\""};
			2: case ($urandom_range(0, 2))
				0: s = "true";
				1: s = "false";
				default: s = "null";
			endcase
			4: begin
				n = $urandom_range(0, 3);
				s = {"[", blank()};
				for (int i = 0; i < n; i++)
					s = {s, (i > 0) ? "," : "", blank(), rand_value(lvl - 1), blank()};
				s = {s, "]"};
			end
			default: begin
				n = $urandom_range(0, 3);
				s = {"{", blank()};
				for (int i = 0; i < n; i++)
					s = {s, (i > 0) ? "," : "", blank(), "\"", rand_text_body(), "\"", blank(),
						":", blank(), rand_value(lvl - 1), blank()};
				s = {s, "}"};
			end
		endcase
		return s;
	endfunction

	// Scalars, both empty containers, every escape and the four UTF-8 lengths.
	task test_directed;
		send_element(" \t\r\n[]");
		send_element("{}");
		send_element("true");
		send_element("false");
		send_element("null");
		send_element("-0");
		send_element("0.5e+3");
		send_element("12E-7");
		send_element("[98]");
		send_element("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
		send_element("\"\\u0041\\u00e9\\u20AC\\uFFFF\\ud83d\\uDE00\"");
		send_element({"\"", string'(8'hff), string'(8'h80), " ~\""});
		send_element("{\"k\" : [ {} ], \"\":{\"a\":1}}");
	endtask

	// Nests objects and arrays in turn well below the stack limit, then unwinds.
	task test_deep_nesting;
		send_element("");
		for (int i = 1; i < DEEP_LEVELS; i++) send_text((i % 2) ? "{\"d\":" : "[");
		send_text("0");
		for (int i = DEEP_LEVELS - 1; i >= 1; i--) send_text((i % 2) ? "}" : "]");
	endtask

	task test_random_values;
		while (sent_items < RANDOM_ITEMS)
			send_element({blank(), rand_value(2), blank()});
	endtask

	// Ends the text cleanly or breaks it in one of the ways the grammar rejects.
	// The first error latches, so only one breakage is reachable per run.
	task test_ending;
		calm = 1'b1;
		case ($urandom_range(0, 11))
			0: begin
				send_text("]");
				send_item(8'h00, 1'b1);
				send_item(8'hff, 1'b1);
				send_text($urandom_range(0, 1) ? " ," : " x");
			end
			1: send_element({"\"a", string'(8'h1f)});
			2: send_element("\"\\q");
			3: send_element("\"\\udc00");
			4: send_element("\"\\ud800x");
			5: send_element("-x");
			6: send_element("tru!");
			7: send_element("{\"k\" 1");
			8: send_element("[}");
			9: begin
				send_element("\"ab");
				send_item(8'h22, 1'b1);
			end
			10: begin
				send_element("");
				repeat (NEST_LIMIT) send_text("[");
			end
			default: send_element("{1");
		endcase
		repeat (4) send_item($urandom_range(0, 255), 1'b0);
		send_item($urandom_range(0, 255), 1'b1);
		s_tvalid <= 1'b0;
	endtask

	// Receiver side: random stall bursts until the closing phase.
	int stall_left = 0;
	always @(posedge clk) begin
		if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0)
			stall_left = $urandom_range(1, 15);
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compares every accepted result with the oldest expected token.
	always @(posedge clk) begin
		token_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (token_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token: kind %0d data %h err %0d last %b",
						m_tdata[3:0], m_tdata[11:4], m_tdata[15:12], m_tlast);
			end else begin
				want = token_q.pop_front();
				if (m_tdata[3:0] !== want.kind || m_tdata[11:4] !== want.data ||
						m_tdata[15:12] !== want.err || m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("token mismatch: expected %0d/%h/%0d/%b got %0d/%h/%0d/%b",
							want.kind, want.data, want.err, want.last,
							m_tdata[3:0], m_tdata[11:4], m_tdata[15:12], m_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		sc_mode = jts_pkg::M_VALUE;
		sc_err = 4'd0;
		sc_stack = '0;
		sc_depth = 0;
		sc_word = 0;
		sc_pos = 0;
		sc_hex = 16'h0000;
		sc_hex_n = 0;
		sc_high = 16'h0000;
		sc_key = 1'b0;
		sc_fresh = 1'b0;
		sc_failed = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);
		// The whole run is one top-level array, so the text stays valid until the end.
		send_text("[");
		first_elem = 1'b1;
		test_directed();
		test_deep_nesting();
		test_random_values();
		test_ending();
		while (token_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && token_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
